// ===== hdl/ags_pkg.sv =====
// Shared types and constants of the adaptive gap segmenter.
`timescale 1ns / 1ps
`default_nettype none

package ags_pkg;

	// Field widths of the point and result transactions.
	localparam int COORD_BITS     = 24;
	localparam int SEGMENT_BITS   = 10;
	localparam int RATIO_BITS     = 8;
	localparam int GAP_BITS       = 23;
	localparam int FRAC_BITS      = 8;
	localparam int CFG_INDEX_BITS = 2;

	// A coordinate difference at or beyond two to this power always breaks.
	localparam int HUGE_SHIFT = 31;

	// Register values after reset.
	localparam logic [RATIO_BITS-1:0] RANGE_RATIO_RESET = RATIO_BITS'(128);
	localparam logic [GAP_BITS-1:0]   MIN_GAP_RESET     = GAP_BITS'(26);
	localparam logic [GAP_BITS-1:0]   MAX_GAP_RESET     = GAP_BITS'(512);

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_RANGE_RATIO = 2'd0,
		CFG_MIN_GAP     = 2'd1,
		CFG_MAX_GAP     = 2'd2
	} cfg_reg_t;

	// One input point.
	typedef struct packed {
		logic signed [COORD_BITS-1:0] point_x;
		logic signed [COORD_BITS-1:0] point_y;
		logic                         ring_end;
	} point_item_t;

	// One pair result.
	typedef struct packed {
		logic                    gap_break;
		logic [SEGMENT_BITS-1:0] segment_number;
		logic                    closing_pair;
		logic                    run_last;
	} result_item_t;

endpackage

`default_nettype wire

// ===== hdl/ags_isqrt.sv =====
// Bit-serial integer square root, one root bit per clock cycle.
`timescale 1ns / 1ps
`default_nettype none

module ags_isqrt #(
	parameter int ROOT_BITS = 24
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic [2*ROOT_BITS-1:0] radicand,
	output logic                        done,
	output logic [ROOT_BITS-1:0]        root
);

	localparam int CNT_W = $clog2(ROOT_BITS + 1);
	localparam int REM_W = ROOT_BITS + 2;

	logic [2*ROOT_BITS-1:0] rad_q;
	logic [REM_W-1:0]       rem_q;
	logic [ROOT_BITS-1:0]   root_q;
	logic [CNT_W-1:0]       count_q;
	logic                   done_q;

	logic [REM_W-1:0] rem_shift;
	logic [REM_W-1:0] trial;
	logic             take;

	// Bring down the next two radicand bits and try the next root bit.
	always_comb begin
		rem_shift = {rem_q[ROOT_BITS-1:0], rad_q[2*ROOT_BITS-1 -: 2]};
		trial     = {root_q, 2'b01};
		take      = (rem_shift >= trial);
	end

	// Iteration registers; the count runs down from the number of root bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rad_q   <= '0;
			rem_q   <= '0;
			root_q  <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rad_q   <= radicand;
				rem_q   <= '0;
				root_q  <= '0;
				count_q <= CNT_W'(ROOT_BITS);
			end else if (count_q != '0) begin
				rad_q   <= rad_q << 2;
				rem_q   <= take ? (rem_shift - trial) : rem_shift;
				root_q  <= {root_q[ROOT_BITS-2:0], take};
				count_q <= count_q - CNT_W'(1);
				if (count_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

`default_nettype wire

// ===== hdl/adaptive_gap_segmenter.sv =====
// Top level of the adaptive gap segmenter: sequencer, shared multiplier and registers.
`timescale 1ns / 1ps
`default_nettype none

// Usage
// Points of a closed ring enter on the in_ channel (valid/stall), one transaction
// per point; ring_end marks the last point of the ring. Each point after the first
// gives one result on the out_ channel for the pair it closes with the point before
// it, and the last point gives a second result for the pair back to the first point.
// Registers are written on the cfg_ channel (valid/ready, always ready); the user
// must write them only while idle, as the block itself does not enforce it. Each
// point is squared and its range taken as a square root; each pair then forms its
// threshold and distance, and the last point runs those steps again for its closing
// pair. The work is set by the bit-serial square root of the range, one root bit per
// cycle, and by the single multiplier that forms all squares and the threshold product
// in turn. in_stall is high while a point is at work, so one point is handled at a time.
// The result sits in an output register; the next point is taken while it waits.
// When the receiver stalls, the sequencer holds in its emit step until the register
// frees. Reset clears the ring state and loads the default register values; no
// result is pending after reset.
module adaptive_gap_segmenter (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire ags_pkg::point_item_t                 in_item,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output ags_pkg::result_item_t                     out_item,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [ags_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  wire logic [ags_pkg::GAP_BITS-1:0]         cfg_data
);

	import ags_pkg::*;

	localparam int MW    = (COORD_BITS > GAP_BITS) ? COORD_BITS : GAP_BITS;
	localparam int ACC_W = 2 * MW + 1;
	localparam logic [SEGMENT_BITS-1:0] SEG_MAX = {SEGMENT_BITS{1'b1}};

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQX,
		ST_SQY,
		ST_ROOT_GO,
		ST_ROOT_WAIT,
		ST_SETUP,
		ST_THR,
		ST_CLAMP,
		ST_TSQ,
		ST_DX,
		ST_DY,
		ST_EMIT
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [RATIO_BITS-1:0] range_ratio_q;
	logic [GAP_BITS-1:0]   min_gap_q;
	logic [GAP_BITS-1:0]   max_gap_q;

	// Current point and ring state.
	logic [COORD_BITS-1:0]   cur_x_q, cur_y_q, cur_r_q;
	logic                    cur_end_q;
	logic [COORD_BITS-1:0]   first_x_q, first_y_q, first_r_q;
	logic [COORD_BITS-1:0]   prev_x_q, prev_y_q, prev_r_q;
	logic                    have_prev_q;
	logic [SEGMENT_BITS-1:0] seg_q;
	logic                    pair_sel_q;

	// Arithmetic registers.
	logic [ACC_W-1:0]      acc_q;
	logic [GAP_BITS-1:0]   thr_q;
	logic [2*GAP_BITS-1:0] tsq_q;

	logic         out_valid_q;
	result_item_t out_item_q;

	// Square root unit.
	logic                    root_start;
	logic                    root_done;
	logic [COORD_BITS-1:0]   root_val;

	ags_isqrt #(
		.ROOT_BITS(COORD_BITS)
	) u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (root_start),
		.radicand(acc_q[2*COORD_BITS-1:0]),
		.done    (root_done),
		.root    (root_val)
	);

	assign root_start = (state_q == ST_ROOT_GO);

	// Magnitudes of the current coordinates.
	logic signed [COORD_BITS:0] cx_ext, cy_ext;
	logic [COORD_BITS:0]        cx_neg, cy_neg;
	logic [COORD_BITS-1:0]      ax, ay;

	always_comb begin
		cx_ext = $signed({cur_x_q[COORD_BITS-1], cur_x_q});
		cy_ext = $signed({cur_y_q[COORD_BITS-1], cur_y_q});
		cx_neg = -cx_ext;
		cy_neg = -cy_ext;
		ax = cur_x_q[COORD_BITS-1] ? cx_neg[COORD_BITS-1:0] : cur_x_q;
		ay = cur_y_q[COORD_BITS-1] ? cy_neg[COORD_BITS-1:0] : cur_y_q;
	end

	// Pair operands: previous to current, or current back to the first point.
	logic [COORD_BITS-1:0]      pa_x, pa_y, pa_r, pb_x, pb_y, pb_r, rmin;
	logic signed [COORD_BITS:0] diff_x, diff_y;
	logic [COORD_BITS:0]        neg_dx, neg_dy;
	logic [COORD_BITS-1:0]      dx, dy;
	logic                       huge;

	always_comb begin
		if (pair_sel_q) begin
			pa_x = cur_x_q;   pa_y = cur_y_q;   pa_r = cur_r_q;
			pb_x = first_x_q; pb_y = first_y_q; pb_r = first_r_q;
		end else begin
			pa_x = prev_x_q;  pa_y = prev_y_q;  pa_r = prev_r_q;
			pb_x = cur_x_q;   pb_y = cur_y_q;   pb_r = cur_r_q;
		end
		rmin   = (pa_r < pb_r) ? pa_r : pb_r;
		diff_x = $signed({pa_x[COORD_BITS-1], pa_x}) - $signed({pb_x[COORD_BITS-1], pb_x});
		diff_y = $signed({pa_y[COORD_BITS-1], pa_y}) - $signed({pb_y[COORD_BITS-1], pb_y});
		neg_dx = -diff_x;
		neg_dy = -diff_y;
		dx = diff_x[COORD_BITS] ? neg_dx[COORD_BITS-1:0] : diff_x[COORD_BITS-1:0];
		dy = diff_y[COORD_BITS] ? neg_dy[COORD_BITS-1:0] : diff_y[COORD_BITS-1:0];
		huge = ((dx >> HUGE_SHIFT) != '0) || ((dy >> HUGE_SHIFT) != '0);
	end

	// Threshold clamp of the scaled nearer range held in the accumulator.
	logic [COORD_BITS-1:0] thr_raw;
	logic [MW-1:0]         thr_ext;
	logic [GAP_BITS-1:0]   thr_clamp;

	always_comb begin
		thr_raw = acc_q[FRAC_BITS +: COORD_BITS];
		thr_ext = MW'(thr_raw);
		if (thr_ext < MW'(min_gap_q)) begin
			thr_clamp = min_gap_q;
		end else if (thr_ext > MW'(max_gap_q)) begin
			thr_clamp = max_gap_q;
		end else begin
			thr_clamp = thr_ext[GAP_BITS-1:0];
		end
	end

	// Shared multiplier operand selection.
	logic [MW-1:0]   mul_a, mul_b;
	logic [2*MW-1:0] product;

	always_comb begin
		case (state_q)
			ST_SQX: begin
				mul_a = MW'(ax);
				mul_b = MW'(ax);
			end
			ST_SQY: begin
				mul_a = MW'(ay);
				mul_b = MW'(ay);
			end
			ST_THR: begin
				mul_a = MW'(range_ratio_q);
				mul_b = MW'(rmin);
			end
			ST_TSQ: begin
				mul_a = MW'(thr_q);
				mul_b = MW'(thr_q);
			end
			ST_DX: begin
				mul_a = MW'(dx);
				mul_b = MW'(dx);
			end
			ST_DY: begin
				mul_a = MW'(dy);
				mul_b = MW'(dy);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		product = mul_a * mul_b;
	end

	logic pair_break;
	logic out_free;
	logic emit_fire;

	assign pair_break = huge || (acc_q > ACC_W'(tsq_q));
	assign out_free   = !out_valid_q || !out_stall;
	assign emit_fire  = (state_q == ST_EMIT) && out_free;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_ratio_q <= RANGE_RATIO_RESET;
			min_gap_q     <= MIN_GAP_RESET;
			max_gap_q     <= MAX_GAP_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_RANGE_RATIO: range_ratio_q <= cfg_data[RATIO_BITS-1:0];
				CFG_MIN_GAP:     min_gap_q     <= cfg_data;
				CFG_MAX_GAP:     max_gap_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer with the ring state and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			cur_r_q     <= '0;
			cur_end_q   <= 1'b0;
			first_x_q   <= '0;
			first_y_q   <= '0;
			first_r_q   <= '0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			prev_r_q    <= '0;
			have_prev_q <= 1'b0;
			seg_q       <= '0;
			pair_sel_q  <= 1'b0;
			acc_q       <= '0;
			thr_q       <= '0;
			tsq_q       <= '0;
			out_valid_q <= 1'b0;
			out_item_q  <= '0;
		end else begin
			// The receiver takes the pending result and no new one replaces it.
			if (out_valid_q && !out_stall && !emit_fire) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cur_x_q   <= in_item.point_x;
						cur_y_q   <= in_item.point_y;
						cur_end_q <= in_item.ring_end;
						state_q   <= ST_SQX;
					end
				end
				ST_SQX: begin
					acc_q   <= ACC_W'(product);
					state_q <= ST_SQY;
				end
				ST_SQY: begin
					acc_q   <= acc_q + ACC_W'(product);
					state_q <= ST_ROOT_GO;
				end
				ST_ROOT_GO: begin
					state_q <= ST_ROOT_WAIT;
				end
				ST_ROOT_WAIT: begin
					if (root_done) begin
						cur_r_q <= root_val;
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					if (have_prev_q) begin
						pair_sel_q <= 1'b0;
						state_q    <= ST_THR;
					end else begin
						// First point of a ring: remember it as the closing target.
						first_x_q <= cur_x_q;
						first_y_q <= cur_y_q;
						first_r_q <= cur_r_q;
						seg_q     <= '0;
						if (cur_end_q) begin
							pair_sel_q <= 1'b1;
							state_q    <= ST_THR;
						end else begin
							prev_x_q    <= cur_x_q;
							prev_y_q    <= cur_y_q;
							prev_r_q    <= cur_r_q;
							have_prev_q <= 1'b1;
							state_q     <= ST_IDLE;
						end
					end
				end
				ST_THR: begin
					acc_q   <= ACC_W'(product);
					state_q <= ST_CLAMP;
				end
				ST_CLAMP: begin
					thr_q   <= thr_clamp;
					state_q <= ST_TSQ;
				end
				ST_TSQ: begin
					tsq_q   <= product[2*GAP_BITS-1:0];
					state_q <= ST_DX;
				end
				ST_DX: begin
					acc_q   <= ACC_W'(product);
					state_q <= ST_DY;
				end
				ST_DY: begin
					acc_q   <= acc_q + ACC_W'(product);
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q                <= 1'b1;
						out_item_q.gap_break      <= pair_break;
						out_item_q.segment_number <= seg_q;
						out_item_q.closing_pair   <= pair_sel_q;
						out_item_q.run_last       <= pair_sel_q;
						prev_x_q <= cur_x_q;
						prev_y_q <= cur_y_q;
						prev_r_q <= cur_r_q;
						if (pair_sel_q) begin
							// Closing pair done: the ring state clears.
							have_prev_q <= 1'b0;
							seg_q       <= '0;
							state_q     <= ST_IDLE;
						end else begin
							have_prev_q <= 1'b1;
							if (pair_break && (seg_q != SEG_MAX)) begin
								seg_q <= seg_q + SEGMENT_BITS'(1);
							end
							if (cur_end_q) begin
								pair_sel_q <= 1'b1;
								state_q    <= ST_THR;
							end else begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;
	assign cfg_ready = 1'b1;

	// An accepted point keeps the block busy in the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("point accepted but the block did not go busy");

	// The root unit finishes only while the sequencer waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		root_done |-> (state_q == ST_ROOT_WAIT))
		else $error("square root finished outside its wait step");

	// A result held by a stalled receiver keeps the sequencer in its emit step.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) && out_valid && out_stall |=> (state_q == ST_EMIT))
		else $error("emit step left while the output register was occupied");

	// Only the closing pair ends a ring.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.closing_pair == out_item.run_last))
		else $error("ring end flag disagrees with closing pair flag");

endmodule

`default_nettype wire
